// File: rtl/mt_sd_pkg.sv
package mt_sd_pkg;

  localparam int unsigned WORD_W = 32;

  localparam logic [WORD_W-1:0] MIX_MUL    = 32'h1F1F_1F1F;
  localparam logic [WORD_W-1:0] SEED_MUL   = 32'd1812433253;
  localparam int unsigned       TWIST_IDX  = 397;
  localparam int unsigned       SEED_SHIFT = 30;
  localparam logic [WORD_W-1:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] MATRIX_A   = 32'd2567483615;
  localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C   = 32'hEFC6_0000;

  typedef struct packed {
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] y;
  } mt_sd_word_t;

endpackage

// File: rtl/mt_sd_in_if.sv
interface mt_sd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] coord_x;
  logic [31:0] coord_z;

  modport source (output valid, output coord_x, output coord_z, input ready);
  modport sink (input valid, input coord_x, input coord_z, output ready);
endinterface

// File: rtl/mt_sd_out_if.sv
interface mt_sd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_draw;
  logic        hit_flag;

  modport source (output valid, output first_draw, output hit_flag, input ready);
  modport sink (input valid, input first_draw, input hit_flag, output ready);
endinterface

// File: rtl/mt_sd_cell.sv
module mt_sd_cell import mt_sd_pkg::*; #(
  parameter int unsigned IDX = 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        valid_in,
  input  mt_sd_word_t data_in,
  output logic        valid_out,
  output mt_sd_word_t data_out
);

  localparam logic [WORD_W-1:0] IDX_W = WORD_W'(IDX);
  localparam bit                FIRST = (IDX == 1);

  logic [WORD_W-1:0] mixed;
  logic [WORD_W-1:0] w_next;
  logic [WORD_W-1:0] y_next;

  always_comb begin
    mixed  = data_in.w ^ (data_in.w >> SEED_SHIFT);
    w_next = SEED_MUL * mixed + IDX_W;
    // word one fixes the twist operand together with the seed's top bit
    if (FIRST) begin
      y_next = (data_in.w & UPPER_MASK) | (w_next & LOWER_MASK);
    end else begin
      y_next = data_in.y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_out.w <= w_next;
      data_out.y <= y_next;
    end
  end

endmodule

// File: rtl/mt_sd_tail.sv
module mt_sd_tail import mt_sd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid_in,
  input  mt_sd_word_t   data_in,
  mt_sd_out_if.source   dout
);

  logic [WORD_W-1:0] twisted;
  logic [WORD_W-1:0] t1;
  logic [WORD_W-1:0] t2;
  logic [WORD_W-1:0] t3;
  logic [WORD_W-1:0] tempered;
  logic              valid_a;
  logic [WORD_W-1:0] draw_a;
  logic [6:0]        nib_sum;
  logic [4:0]        fold;
  logic              div5;
  logic              hit;

  always_comb begin
    twisted = data_in.w ^ (data_in.y >> 1);
    if (data_in.y[0]) begin
      twisted = twisted ^ MATRIX_A;
    end
    t1       = twisted ^ (twisted >> 11);
    t2       = t1 ^ ((t1 << 7) & TEMPER_B);
    t3       = t2 ^ ((t2 << 15) & TEMPER_C);
    tempered = t3 ^ (t3 >> 18);
  end

  // sixteen is one modulo five, so nibble sums keep the residue
  always_comb begin
    nib_sum = '0;
    for (int k = 0; k < WORD_W / 4; k++) begin
      nib_sum = nib_sum + 7'(draw_a[4*k +: 4]);
    end
    fold = 5'(nib_sum[6:4]) + 5'(nib_sum[3:0]);
    div5 = (fold == 5'd0) || (fold == 5'd5) || (fold == 5'd10) ||
           (fold == 5'd15) || (fold == 5'd20);
    hit  = div5 && !draw_a[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a    <= 1'b0;
      dout.valid <= 1'b0;
    end else if (en) begin
      valid_a    <= valid_in;
      dout.valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      draw_a          <= tempered;
      dout.first_draw <= draw_a;
      dout.hit_flag   <= hit;
    end
  end

endmodule

// File: rtl/mt_seed_first_draw_test_unit.sv
// path: mix register, 397 seeding cells, then the tail's draw and output registers
// throughput: one word per cycle while no result waits, set by the 397 seeding cells, one multiplier each
// the whole chain advances together and holds while a result waits to be taken
// rst is synchronous, active high, and clears the valid bits only
module mt_seed_first_draw_test_unit import mt_sd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mt_sd_in_if.sink    din,
  mt_sd_out_if.source dout
);

  logic              adv;
  logic              mix_valid;
  logic [WORD_W-1:0] mix_prod;
  logic [WORD_W-1:0] mix_z;
  logic              chain_valid [0:TWIST_IDX];
  mt_sd_word_t       chain_data  [0:TWIST_IDX];

  assign adv       = !dout.valid || dout.ready;
  assign din.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
    end else if (adv) begin
      mix_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mix_prod <= din.coord_x * MIX_MUL;
      mix_z    <= din.coord_z;
    end
  end

  assign chain_valid[0]  = mix_valid;
  assign chain_data[0].w = mix_prod ^ mix_z;
  assign chain_data[0].y = '0;

  for (genvar i = 1; i <= TWIST_IDX; i++) begin : g_cell
    mt_sd_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .valid_in (chain_valid[i-1]),
      .data_in  (chain_data[i-1]),
      .valid_out(chain_valid[i]),
      .data_out (chain_data[i])
    );
  end

  mt_sd_tail u_tail (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .valid_in(chain_valid[TWIST_IDX]),
    .data_in (chain_data[TWIST_IDX]),
    .dout    (dout)
  );

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !dout.valid)
    else $error("result valid right after reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready |=> mix_valid)
    else $error("accepted word lost at the mix stage");

  a_chain_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(chain_valid[TWIST_IDX]) && $stable(chain_data[TWIST_IDX]))
    else $error("chain moved during an output stall");

  a_flag_even: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.hit_flag |-> !dout.first_draw[0])
    else $error("hit flag on an odd draw");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    dout.valid && (dout.first_draw == '0) |-> dout.hit_flag)
    else $error("zero draw not flagged");
`endif

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import mt_sd_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES = 450;
  localparam int unsigned HOLD_CYCLES  = 1200;
  localparam int unsigned PHASE_ITEMS  = 400;

  typedef struct {
    logic [WORD_W-1:0] first_draw;
    logic              hit_flag;
  } draw_t;

  class draw_board;
    draw_t       pending_draws[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function void note_pair(logic [WORD_W-1:0] x, logic [WORD_W-1:0] z);
      logic [WORD_W-1:0] seed;
      logic [WORD_W-1:0] w1;
      logic [WORD_W-1:0] w;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] v;
      int unsigned       i;
      draw_t             e;
      seed = x * MIX_MUL;
      seed = seed ^ z;
      w = seed;
      w1 = '0;
      for (i = 1; i <= TWIST_IDX; i++) begin
        w = SEED_MUL * (w ^ (w >> SEED_SHIFT)) + i;
        if (i == 1) begin
          w1 = w;
        end
      end
      y = (seed & UPPER_MASK) | (w1 & LOWER_MASK);
      v = w ^ (y >> 1);
      if (y[0]) begin
        v = v ^ MATRIX_A;
      end
      // tempering
      v = v ^ (v >> 11);
      v = v ^ ((v << 7) & TEMPER_B);
      v = v ^ ((v << 15) & TEMPER_C);
      v = v ^ (v >> 18);
      e.first_draw = v;
      e.hit_flag = ((v % 10) == 0);
      pending_draws = {pending_draws, e};
    endfunction

    function void check_draw(logic [WORD_W-1:0] draw, logic hit);
      draw_t e;
      if (pending_draws.size() == 0) begin
        $display("%0t: unexpected result word draw=%h hit=%b", $time, draw, hit);
        errors++;
      end else begin
        e = pending_draws.pop_front();
        if (draw !== e.first_draw) begin
          $display("%0t: first_draw expected %h actual %h", $time, e.first_draw, draw);
          errors++;
        end
        if (hit !== e.hit_flag) begin
          $display("%0t: hit_flag expected %b actual %b (draw %h)", $time, e.hit_flag, hit,
                   e.first_draw);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  mt_sd_in_if  in_ch();
  mt_sd_out_if out_ch();

  mt_seed_first_draw_test_unit DUT (
    .clk  (clk),
    .rst  (rst),
    .din  (in_ch),
    .dout (out_ch)
  );

  draw_board   board = new();
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      quiet_cycles++;
      if (in_ch.valid && in_ch.ready) begin
        board.note_pair(in_ch.coord_x, in_ch.coord_z);
        quiet_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        board.check_draw(out_ch.first_draw, out_ch.hit_flag);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d results outstanding", $time,
                 quiet_cycles, board.pending_draws.size());
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  task automatic send_pair(input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.coord_x <= x;
    in_ch.coord_z <= z;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
  endtask

  function automatic logic [WORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(31);
      3:       return ~(32'h1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned count);
    int unsigned n;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (n = 0; n < count; n++) begin
      send_pair(rand_coord(), rand_coord());
    end
  endtask

  initial begin
    int unsigned b;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    quiet_cycles   = 0;
    rst            <= 1'b1;
    in_ch.valid    <= 1'b0;
    in_ch.coord_x  <= '0;
    in_ch.coord_z  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words: extremes and walking bits
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h0000_0000, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'h0000_0000);
    send_pair(32'h0000_0001, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'h0000_0001);
    send_pair(32'h8000_0000, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'h8000_0000);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pair(32'h0000_0001, 32'h1F1F_1F1F);
    for (b = 0; b < 32; b += 3) begin
      send_pair(32'h1 << b, ~(32'h1 << (31 - b)));
    end

    // back-pressure: receiver holds off while words keep coming
    hold_left = HOLD_CYCLES;
    run_phase(0, 0, PHASE_ITEMS);
    run_phase(47, 0, PHASE_ITEMS);
    run_phase(0, 47, PHASE_ITEMS);
    run_phase(19, 19, PHASE_ITEMS);
    in_ch.valid <= 1'b0;

    while (board.pending_draws.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: mt_seed_first_draw_test_unit.f
rtl/mt_sd_pkg.sv
rtl/mt_sd_in_if.sv
rtl/mt_sd_out_if.sv
rtl/mt_sd_cell.sv
rtl/mt_sd_tail.sv
rtl/mt_seed_first_draw_test_unit.sv
verif/tb.sv
